>>> design/frpr_pkg.sv
// Shared types, register and command codes, and fixed-point helpers for the root finder.
`default_nettype none
package frpr_pkg;

  localparam int DATA_W  = 64;
  localparam int PROD_W  = 128;
  localparam int CFG_IW  = 3;
  localparam int LIMIT_W = 11;
  localparam int TOL_W   = 63;
  localparam int CAUSE_W = 2;
  localparam int NCOEF   = 6;
  localparam int DEG_W   = 3;
  localparam int DCNT_W  = 7;

  localparam logic [DATA_W-1:0] SAT_NEG = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_COEF_DEG5  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COEF_DEG4  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_COEF_DEG3  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_COEF_DEG2  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_COEF_DEG1  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_COEF_DEG0  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_TOLERANCE  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_ITER_LIMIT = 3'd7;

  // Stop causes
  localparam logic [CAUSE_W-1:0] CAUSE_WIDTH    = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_RESIDUAL = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_LIMIT    = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_ZERO_DIV = 2'd3;

  // Datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_EV_INIT   = 4'd2;
  localparam logic [3:0] OP_MUL       = 4'd3;
  localparam logic [3:0] OP_EV_ADD    = 4'd4;
  localparam logic [3:0] OP_EV_STORE  = 4'd5;
  localparam logic [3:0] OP_NUM1      = 4'd6;
  localparam logic [3:0] OP_NUM2      = 4'd7;
  localparam logic [3:0] OP_DIV_SETUP = 4'd8;
  localparam logic [3:0] OP_DIV_STEP  = 4'd9;
  localparam logic [3:0] OP_DIV_END   = 4'd10;
  localparam logic [3:0] OP_UPDATE    = 4'd11;
  localparam logic [3:0] OP_FINISH    = 4'd12;

  // Operand selects: evaluation point, or multiplier pairing
  localparam logic [1:0] SEL_A      = 2'd0;
  localparam logic [1:0] SEL_B      = 2'd1;
  localparam logic [1:0] SEL_X      = 2'd2;
  localparam logic [1:0] MUL_HORNER = 2'd0;
  localparam logic [1:0] MUL_AFB    = 2'd1;
  localparam logic [1:0] MUL_BFA    = 2'd2;

  typedef struct packed {
    logic [3:0]         op;
    logic [1:0]         sel;
    logic [CAUSE_W-1:0] cause;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic deg_zero;
    logic limit_hit;
    logic div_zero;
    logic div_ovf;
    logic div_done;
    logic width_small;
    logic resid_small;
    logic out_free;
  } dp_stat_t;

  function automatic logic [DATA_W-1:0] mag64(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 64'd1) : v;
  endfunction

  // Apply a sign to a magnitude, clamping to the signed range
  function automatic logic [DATA_W-1:0] sat_signed(input logic negative,
                                                   input logic [DATA_W-1:0] m,
                                                   input logic ovf);
    logic [DATA_W-1:0] r;
    if (negative) begin
      r = (ovf || (m > SAT_NEG)) ? SAT_NEG : (~m + 64'd1);
    end else begin
      r = (ovf || (m > SAT_POS)) ? SAT_POS : m;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    r = a + b;
    if ((a[DATA_W-1] == b[DATA_W-1]) && (r[DATA_W-1] != a[DATA_W-1])) begin
      r = a[DATA_W-1] ? SAT_NEG : SAT_POS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/frpr_in_if.sv
// Input channel: one bracketing interval per word.
`default_nettype none
interface frpr_in_if;
  logic                          valid;
  logic                          ready;
  logic [frpr_pkg::DATA_W-1:0]   lower_bound;
  logic [frpr_pkg::DATA_W-1:0]   upper_bound;
  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface
`default_nettype wire

>>> design/frpr_out_if.sv
// Result channel: root estimate, stop cause and iteration count per word.
`default_nettype none
interface frpr_out_if;
  logic                           valid;
  logic                           ready;
  logic [frpr_pkg::DATA_W-1:0]    root_estimate;
  logic [frpr_pkg::CAUSE_W-1:0]   stop_cause;
  logic [frpr_pkg::LIMIT_W-1:0]   iterations_used;
  modport source (output valid, output root_estimate, output stop_cause,
                  output iterations_used, input ready);
  modport sink   (input valid, input root_estimate, input stop_cause,
                  input iterations_used, output ready);
endinterface
`default_nettype wire

>>> design/frpr_cfg_if.sv
// Configuration write channel: register index and data per word.
`default_nettype none
interface frpr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [frpr_pkg::CFG_IW-1:0]   index;
  logic [frpr_pkg::DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/frpr_mul.sv
// Sequential 64x64 unsigned multiplier, one 32x32 partial product per cycle.
`default_nettype none
module frpr_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [frpr_pkg::DATA_W-1:0]   opa,
  input  wire logic [frpr_pkg::DATA_W-1:0]   opb,
  output logic                               busy,
  output logic [frpr_pkg::PROD_W-1:0]        prod
);
  logic [frpr_pkg::DATA_W-1:0] a_r, b_r;
  logic [frpr_pkg::PROD_W-1:0] acc_r, acc_nxt, pp_sh;
  logic [1:0]                  k_r;
  logic                        busy_r;
  logic [31:0]                 ah, bh;
  logic [63:0]                 pp;

  // Pick halves for this step and align the partial product
  always_comb begin
    ah = k_r[1] ? a_r[63:32] : a_r[31:0];
    bh = k_r[0] ? b_r[63:32] : b_r[31:0];
    pp = ah * bh;
    unique case (k_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    acc_nxt = acc_r + pp_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 2'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      k_r    <= 2'd0;
    end else if (busy_r) begin
      k_r <= k_r + 2'd1;
      if (k_r == 2'd3) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= opa;
      b_r   <= opb;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

>>> design/frpr_datapath.sv
// Datapath: configuration registers, bracket state, Horner evaluator, divider, result register.
`default_nettype none
module frpr_datapath #(
  parameter int POLY_DEGREE   = 5,
  parameter int FRACTION_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire frpr_pkg::dp_cmd_t               cmd,
  output frpr_pkg::dp_stat_t                   stat,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [frpr_pkg::CFG_IW-1:0]     cfg_index,
  input  wire logic [frpr_pkg::DATA_W-1:0]     cfg_data,
  // input payload
  input  wire logic [frpr_pkg::DATA_W-1:0]     lower_bound,
  input  wire logic [frpr_pkg::DATA_W-1:0]     upper_bound,
  // result
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [frpr_pkg::DATA_W-1:0]          root_estimate,
  output logic [frpr_pkg::CAUSE_W-1:0]         stop_cause,
  output logic [frpr_pkg::LIMIT_W-1:0]         iterations_used
);
  localparam int FB = FRACTION_BITS;

  logic [frpr_pkg::DATA_W-1:0]  coef_r [frpr_pkg::NCOEF];
  logic [frpr_pkg::TOL_W-1:0]   tol_r;
  logic [frpr_pkg::LIMIT_W-1:0] limit_r;

  logic [frpr_pkg::DATA_W-1:0]  a_r, b_r, fa_r, fb_r, x_r, fx_r, y_r, hx_r;
  logic [frpr_pkg::LIMIT_W-1:0] count_r;
  logic [frpr_pkg::DEG_W-1:0]   deg_r;
  logic                         msgn_r;
  logic [frpr_pkg::PROD_W-1:0]  p1_r, num_r;
  logic [frpr_pkg::DATA_W-1:0]  rem_r, nl_r, dv_r, q_r;
  logic [frpr_pkg::DCNT_W-1:0]  dcnt_r;
  logic                         qneg_r, ovf_r;

  logic                         out_valid_r;
  logic [frpr_pkg::DATA_W-1:0]  root_r;
  logic [frpr_pkg::CAUSE_W-1:0] cause_r;
  logic [frpr_pkg::LIMIT_W-1:0] iters_r;

  logic                         mul_start, mul_busy;
  logic [frpr_pkg::DATA_W-1:0]  mul_a, mul_b;
  logic                         mul_sgn;
  logic [frpr_pkg::PROD_W-1:0]  prod, sprod, num_abs;
  logic [frpr_pkg::DATA_W-1:0]  fxm, ev_sum, dvd, width, rem_sh, fx_mag;
  logic                         dneg, rem_carry, rem_ge;

  // Multiplier operand selection and sign of the product
  always_comb begin
    mul_start = (cmd.op == frpr_pkg::OP_MUL);
    unique case (cmd.sel)
      frpr_pkg::MUL_AFB: begin
        mul_a = frpr_pkg::mag64(a_r);
        mul_b = frpr_pkg::mag64(fb_r);
        mul_sgn = a_r[63] ^ fb_r[63];
      end
      frpr_pkg::MUL_BFA: begin
        mul_a = frpr_pkg::mag64(b_r);
        mul_b = frpr_pkg::mag64(fa_r);
        mul_sgn = b_r[63] ^ fa_r[63];
      end
      default: begin
        mul_a = frpr_pkg::mag64(y_r);
        mul_b = frpr_pkg::mag64(hx_r);
        mul_sgn = y_r[63] ^ hx_r[63];
      end
    endcase
  end

  frpr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .opa   (mul_a),
    .opb   (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  // Fixed-point product, Horner sum, and numerator pieces
  always_comb begin
    fxm     = frpr_pkg::sat_signed(msgn_r, prod[FB+63:FB], |prod[127:FB+64]);
    ev_sum  = frpr_pkg::sat_add(fxm, coef_r[deg_r]);
    sprod   = msgn_r ? (~prod + 128'd1) : prod;
    num_abs = num_r[127] ? (~num_r + 128'd1) : num_r;
    dneg    = $signed(fb_r) < $signed(fa_r);
    dvd     = dneg ? (fa_r - fb_r) : (fb_r - fa_r);
    width   = ($signed(a_r) < $signed(b_r)) ? (b_r - a_r) : (a_r - b_r);
    fx_mag  = frpr_pkg::mag64(fx_r);
  end

  // One restoring division step
  always_comb begin
    rem_carry = rem_r[63];
    rem_sh    = {rem_r[62:0], nl_r[63]};
    rem_ge    = rem_carry || (rem_sh >= dv_r);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[5] <= 64'd1 << (FB - 1);
      coef_r[4] <= 64'd3 << (FB - 1);
      coef_r[3] <= 64'd0 - (64'd2 << FB);
      coef_r[2] <= 64'd0 - (64'd5 << FB);
      coef_r[1] <= 64'd1 << FB;
      coef_r[0] <= 64'd2 << FB;
      tol_r     <= 63'd1;
      limit_r   <= 11'd64;
    end else if (cfg_we) begin
      priority if (cfg_index <= frpr_pkg::REG_COEF_DEG0) begin
        coef_r[frpr_pkg::REG_COEF_DEG0 - cfg_index] <= cfg_data;
      end else if (cfg_index == frpr_pkg::REG_TOLERANCE) begin
        tol_r <= cfg_data[frpr_pkg::TOL_W-1:0];
      end else begin
        limit_r <= cfg_data[frpr_pkg::LIMIT_W-1:0];
      end
    end
  end

  // Result word handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == frpr_pkg::OP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Working registers, driven by the controller's operation
  always_ff @(posedge clk) begin
    if (mul_start) msgn_r <= mul_sgn;
    unique case (cmd.op)
      frpr_pkg::OP_LOAD: begin
        a_r     <= lower_bound;
        b_r     <= upper_bound;
        x_r     <= lower_bound;
        count_r <= '0;
      end
      frpr_pkg::OP_EV_INIT: begin
        y_r   <= coef_r[frpr_pkg::DEG_W'(POLY_DEGREE)];
        deg_r <= frpr_pkg::DEG_W'(POLY_DEGREE - 1);
        unique case (cmd.sel)
          frpr_pkg::SEL_A: hx_r <= a_r;
          frpr_pkg::SEL_B: hx_r <= b_r;
          default:         hx_r <= x_r;
        endcase
      end
      frpr_pkg::OP_EV_ADD: begin
        y_r   <= ev_sum;
        deg_r <= deg_r - 3'd1;
      end
      frpr_pkg::OP_EV_STORE: begin
        unique case (cmd.sel)
          frpr_pkg::SEL_A: fa_r <= y_r;
          frpr_pkg::SEL_B: fb_r <= y_r;
          default:         fx_r <= y_r;
        endcase
      end
      frpr_pkg::OP_NUM1: p1_r  <= sprod;
      frpr_pkg::OP_NUM2: num_r <= p1_r - sprod;
      frpr_pkg::OP_DIV_SETUP: begin
        rem_r  <= num_abs[127:64];
        nl_r   <= num_abs[63:0];
        dv_r   <= dvd;
        q_r    <= '0;
        dcnt_r <= '0;
        qneg_r <= num_r[127] ^ dneg;
        ovf_r  <= num_abs[127:64] >= dvd;
      end
      frpr_pkg::OP_DIV_STEP: begin
        rem_r  <= rem_ge ? (rem_sh - dv_r) : rem_sh;
        nl_r   <= {nl_r[62:0], 1'b0};
        q_r    <= {q_r[62:0], rem_ge};
        dcnt_r <= dcnt_r + 7'd1;
      end
      frpr_pkg::OP_DIV_END: x_r <= frpr_pkg::sat_signed(qneg_r, q_r, ovf_r);
      frpr_pkg::OP_UPDATE: begin
        count_r <= count_r + 11'd1;
        if ((fx_r != '0) && (fa_r != '0) && (fx_r[63] != fa_r[63])) begin
          b_r  <= x_r;
          fb_r <= fx_r;
        end else begin
          a_r  <= x_r;
          fa_r <= fx_r;
        end
      end
      frpr_pkg::OP_FINISH: begin
        root_r  <= x_r;
        cause_r <= cmd.cause;
        iters_r <= count_r;
      end
      default: ;
    endcase
  end

  // Status back to the controller
  always_comb begin
    stat.mul_busy    = mul_busy;
    stat.deg_zero    = (deg_r == '0);
    stat.limit_hit   = (count_r >= limit_r);
    stat.div_zero    = (fa_r == fb_r);
    stat.div_ovf     = ovf_r;
    stat.div_done    = dcnt_r[frpr_pkg::DCNT_W-1];
    stat.width_small = width < {1'b0, tol_r};
    stat.resid_small = fx_mag < {1'b0, tol_r};
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign root_estimate   = root_r;
  assign stop_cause      = cause_r;
  assign iterations_used = iters_r;
endmodule
`default_nettype wire

>>> design/frpr_ctrl.sv
// Controller: sequences evaluation, secant point, division and stop tests for one interval.
`default_nettype none
module frpr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire frpr_pkg::dp_stat_t  stat,
  output frpr_pkg::dp_cmd_t        cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVI  = 4'd1;
  localparam logic [3:0] S_EVM  = 4'd2;
  localparam logic [3:0] S_EVW  = 4'd3;
  localparam logic [3:0] S_EVS  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M1W  = 4'd7;
  localparam logic [3:0] S_M2   = 4'd8;
  localparam logic [3:0] S_M2W  = 4'd9;
  localparam logic [3:0] S_DSET = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_UPD  = 4'd12;
  localparam logic [3:0] S_TST  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0]                      state_r, state_nxt;
  logic [1:0]                      ev_sel_r, ev_sel_nxt;
  logic [frpr_pkg::CAUSE_W-1:0]    cause_r, cause_nxt;

  always_comb begin
    state_nxt  = state_r;
    ev_sel_nxt = ev_sel_r;
    cause_nxt  = cause_r;
    cmd.op     = frpr_pkg::OP_NONE;
    cmd.sel    = ev_sel_r;
    cmd.cause  = cause_r;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = frpr_pkg::OP_LOAD;
          ev_sel_nxt = frpr_pkg::SEL_A;
          state_nxt  = S_EVI;
        end
      end
      S_EVI: begin
        cmd.op    = frpr_pkg::OP_EV_INIT;
        state_nxt = S_EVM;
      end
      S_EVM: begin
        cmd.op    = frpr_pkg::OP_MUL;
        cmd.sel   = frpr_pkg::MUL_HORNER;
        state_nxt = S_EVW;
      end
      S_EVW: begin
        if (!stat.mul_busy) begin
          cmd.op    = frpr_pkg::OP_EV_ADD;
          state_nxt = stat.deg_zero ? S_EVS : S_EVM;
        end
      end
      S_EVS: begin
        cmd.op = frpr_pkg::OP_EV_STORE;
        unique case (ev_sel_r)
          frpr_pkg::SEL_A: begin
            ev_sel_nxt = frpr_pkg::SEL_B;
            state_nxt  = S_EVI;
          end
          frpr_pkg::SEL_B: state_nxt = S_CHK;
          default:         state_nxt = S_UPD;
        endcase
      end
      // limit first, then a flat secant
      S_CHK: begin
        priority if (stat.limit_hit) begin
          cause_nxt = frpr_pkg::CAUSE_LIMIT;
          state_nxt = S_FIN;
        end else if (stat.div_zero) begin
          cause_nxt = frpr_pkg::CAUSE_ZERO_DIV;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        cmd.op    = frpr_pkg::OP_MUL;
        cmd.sel   = frpr_pkg::MUL_AFB;
        state_nxt = S_M1W;
      end
      S_M1W: begin
        if (!stat.mul_busy) begin
          cmd.op    = frpr_pkg::OP_NUM1;
          state_nxt = S_M2;
        end
      end
      S_M2: begin
        cmd.op    = frpr_pkg::OP_MUL;
        cmd.sel   = frpr_pkg::MUL_BFA;
        state_nxt = S_M2W;
      end
      S_M2W: begin
        if (!stat.mul_busy) begin
          cmd.op    = frpr_pkg::OP_NUM2;
          state_nxt = S_DSET;
        end
      end
      S_DSET: begin
        cmd.op    = frpr_pkg::OP_DIV_SETUP;
        state_nxt = S_DIV;
      end
      // quotient overflow skips the bit loop
      S_DIV: begin
        if (stat.div_ovf || stat.div_done) begin
          cmd.op     = frpr_pkg::OP_DIV_END;
          ev_sel_nxt = frpr_pkg::SEL_X;
          state_nxt  = S_EVI;
        end else begin
          cmd.op = frpr_pkg::OP_DIV_STEP;
        end
      end
      S_UPD: begin
        cmd.op    = frpr_pkg::OP_UPDATE;
        state_nxt = S_TST;
      end
      S_TST: begin
        priority if (stat.width_small) begin
          cause_nxt = frpr_pkg::CAUSE_WIDTH;
          state_nxt = S_FIN;
        end else if (stat.resid_small) begin
          cause_nxt = frpr_pkg::CAUSE_RESIDUAL;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = frpr_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ev_sel_r <= frpr_pkg::SEL_A;
      cause_r  <= frpr_pkg::CAUSE_WIDTH;
    end else begin
      state_r  <= state_nxt;
      ev_sel_r <= ev_sel_nxt;
      cause_r  <= cause_nxt;
    end
  end
endmodule
`default_nettype wire

>>> design/false_position_root_finder_unit.sv
// Top level of the false-position polynomial root finder.
//
//  channel  dir  word
//  in_ch    in   lower_bound, upper_bound (signed fixed point)
//  out_ch   out  root_estimate, stop_cause, iterations_used
//  cfg_ch   in   index, data (coefficients deg5..deg0, tolerance, limit)
//
// One interval at a time. Each polynomial evaluation uses one product per Horner
// step; each iteration adds two products, a 64-step bit-serial divider and an
// evaluation, and the divider skips its bit loop when the quotient saturates. An
// item evaluates both bounds first, then iterates until a stop test fires.
// Reset is synchronous; the result register holds a word until taken, and the
// next interval is accepted as soon as the previous result is registered.
`default_nettype none
module false_position_root_finder_unit #(
  parameter int POLY_DEGREE   = 5,
  parameter int FRACTION_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  frpr_in_if.sink       in_ch,
  frpr_out_if.source    out_ch,
  frpr_cfg_if.sink      cfg_ch
);
  frpr_pkg::dp_cmd_t  cmd;
  frpr_pkg::dp_stat_t stat;
  logic               in_ready;

  frpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  frpr_datapath #(
    .POLY_DEGREE   (POLY_DEGREE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .lower_bound     (in_ch.lower_bound),
    .upper_bound     (in_ch.upper_bound),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .root_estimate   (out_ch.root_estimate),
    .stop_cause      (out_ch.stop_cause),
    .iterations_used (out_ch.iterations_used)
  );

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
endmodule
`default_nettype wire

>>> design/frpr_checker.sv
// Port-level checks for the root finder, bound to the top level.
`default_nettype none
module frpr_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [63:0] root_estimate,
  input  wire logic [1:0]  stop_cause,
  input  wire logic [10:0] iterations_used,
  input  wire logic        cfg_ready
);
  // a held result word keeps its root estimate and stop cause
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(root_estimate) && $stable(stop_cause))
    else $error("result word changed while stalled");

  // one interval in flight: no new word straight after an accepted one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // width and residual stops only follow at least one estimate
  a_tol_stop_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (stop_cause == frpr_pkg::CAUSE_WIDTH ||
                  stop_cause == frpr_pkg::CAUSE_RESIDUAL) |-> iterations_used != 11'd0)
    else $error("tolerance stop with no iteration");

  // configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");
endmodule

bind false_position_root_finder_unit frpr_checker u_frpr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .root_estimate   (out_ch.root_estimate),
  .stop_cause      (out_ch.stop_cause),
  .iterations_used (out_ch.iterations_used),
  .cfg_ready       (cfg_ch.ready)
);
`default_nettype wire
